/* hw/rtl/line_token_classifier_assert.svh */
// Assertion helpers shared by the classifier modules.
// Each expects clk and rst_n in scope.
`ifndef LINE_TOKEN_CLASSIFIER_ASSERT_SVH
`define LINE_TOKEN_CLASSIFIER_ASSERT_SVH

`define LTC_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define LTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define LTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ltc_pkg.sv */
package ltc_pkg;

    localparam int unsigned LTC_MAX_LEN = 255;
    localparam int NUM_KW = 13;
    localparam int RES_SLOTS = 3;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] CNT_SAT = 4'd8;

    typedef enum logic [2:0] {
        CLS_KEYWORD = 3'd0,
        CLS_IDENT   = 3'd1,
        CLS_CONST   = 3'd2,
        CLS_ERROR   = 3'd3,
        CLS_OP      = 3'd4,
        CLS_COMMENT = 3'd5,
        CLS_EOL     = 3'd6
    } cls_t;

    typedef enum logic [3:0] {
        NUM_START    = 4'd0,
        NUM_SIGN     = 4'd1,
        NUM_INT      = 4'd2,
        NUM_DOT      = 4'd3,
        NUM_FRAC     = 4'd4,
        NUM_EXP      = 4'd5,
        NUM_EXP_SIGN = 4'd6,
        NUM_EXP_INT  = 4'd7,
        NUM_DEAD     = 4'd8
    } num_t;

    typedef enum logic {
        ACT_CHAR = 1'b0,
        ACT_EOL  = 1'b1
    } act_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
    } char_item_t;

    typedef struct packed {
        logic [2:0] token_class;
        logic [7:0] token_length;
        logic       last_of_run;
    } token_item_t;

    typedef struct packed {
        logic [1:0]                   count;
        token_item_t [RES_SLOTS-1:0] items;
    } token_group_t;

    // running class checks of the pending text
    typedef struct packed {
        logic              has_text;
        logic              ident_ok;
        num_t              num;
        logic [NUM_KW-1:0] hits;
        logic [CNT_W-1:0]  text_count;
    } text_check_t;

    localparam text_check_t CHK_CLEAR = '{
        has_text:   1'b0,
        ident_ok:   1'b1,
        num:        NUM_START,
        hits:       {NUM_KW{1'b1}},
        text_count: '0
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic num_t number_next(input num_t s, input logic [7:0] c);
        logic d;
        d = is_digit(c);
        unique case (s)
            NUM_START:    return (c == CH_MINUS) ? NUM_SIGN : (d ? NUM_INT : NUM_DEAD);
            NUM_SIGN:     return d ? NUM_INT : NUM_DEAD;
            NUM_INT:      return d ? NUM_INT : ((c == CH_DOT) ? NUM_DOT : NUM_DEAD);
            NUM_DOT:      return d ? NUM_FRAC : NUM_DEAD;
            NUM_FRAC:     return d ? NUM_FRAC :
                                 (((c == CH_LOW_E) || (c == CH_UP_E)) ? NUM_EXP : NUM_DEAD);
            NUM_EXP:      return (c == CH_MINUS) ? NUM_EXP_SIGN : (d ? NUM_EXP_INT : NUM_DEAD);
            NUM_EXP_SIGN: return d ? NUM_EXP_INT : NUM_DEAD;
            NUM_EXP_INT:  return d ? NUM_EXP_INT : NUM_DEAD;
            default:      return NUM_DEAD;
        endcase
    endfunction

    // keyword text, left justified, zero padded
    function automatic logic [63:0] kw_word(input logic [3:0] k);
        unique case (k)
            4'd0:    return {"program", 8'h00};
            4'd1:    return {"begin", 24'h0};
            4'd2:    return {"read", 32'h0};
            4'd3:    return {"var", 40'h0};
            4'd4:    return {"int", 40'h0};
            4'd5:    return {"integer", 8'h00};
            4'd6:    return {"float", 24'h0};
            4'd7:    return {"real", 32'h0};
            4'd8:    return {"end", 40'h0};
            4'd9:    return {"write", 24'h0};
            4'd10:   return {"print", 24'h0};
            4'd11:   return {"pause", 24'h0};
            4'd12:   return {"none", 32'h0};
            default: return '0;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] kw_len(input logic [3:0] k);
        unique case (k)
            4'd0, 4'd5:                return 4'd7;
            4'd1, 4'd6, 4'd9, 4'd10,
            4'd11:                     return 4'd5;
            4'd2, 4'd7, 4'd12:         return 4'd4;
            4'd3, 4'd4, 4'd8:          return 4'd3;
            default:                   return 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
        logic [63:0] w;
        w = kw_word(k);
        return w[8*(7-int'(p)) +: 8];
    endfunction

endpackage

/* hw/rtl/line_token_classifier.sv */
// The tokens of an accepted character are registered in the group queue and offered
// from its head. Throughput: one character per cycle while each yields at most one
// token and token_ready stays high; a character that yields several tokens holds the
// output until all are taken, buffered by a two-group queue. Reset (rst_n low,
// asynchronous) clears the scanner state and empties the queue; char_ready is then high.
module line_token_classifier #(
    parameter int unsigned MAX_LEN = ltc_pkg::LTC_MAX_LEN
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  ltc_pkg::char_item_t  char_item,
    output logic                 token_valid,
    input  logic                 token_ready,
    output ltc_pkg::token_item_t token_item
);

    logic                  accept;
    ltc_pkg::token_group_t group;

    assign accept = char_valid && char_ready;

    ltc_scan #(
        .MAX_LEN (MAX_LEN)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (char_item),
        .group  (group)
    );

    ltc_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (accept && (group.count != 2'd0)),
        .push_group  (group),
        .space       (char_ready),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_item  (token_item)
    );

endmodule

/* hw/rtl/ltc_scan.sv */
module ltc_scan #(
    parameter int unsigned MAX_LEN = ltc_pkg::LTC_MAX_LEN
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  ltc_pkg::char_item_t  item,
    output ltc_pkg::token_group_t group
);

    `include "line_token_classifier_assert.svh"

    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int LW8 = (LW > 8) ? LW : 8;

    typedef struct packed {
        ltc_pkg::token_group_t grp;
        ltc_pkg::text_check_t  chk;
        logic [LW-1:0]         len;
    } scan_t;

    logic                 minus_reg, minus_next;
    logic                 comment_reg, comment_next;
    ltc_pkg::text_check_t chk_reg;
    logic [LW-1:0]        len_reg;
    scan_t                s;
    logic                 minus_op;
    logic [7:0]           c;

    function automatic logic [LW-1:0] sat_inc(input logic [LW-1:0] x);
        return (x < LW'(MAX_LEN)) ? x + 1'b1 : LW'(MAX_LEN);
    endfunction

    function automatic logic [7:0] out_len(input logic [LW-1:0] x);
        logic [LW8-1:0] wide;
        wide = LW8'(x);
        return (wide > LW8'(255)) ? 8'hFF : wide[7:0];
    endfunction

    function automatic ltc_pkg::text_check_t feed(input ltc_pkg::text_check_t t,
                                                  input logic [7:0] ch);
        ltc_pkg::text_check_t r;
        r = t;
        r.ident_ok = t.has_text ? (t.ident_ok && ltc_pkg::is_word(ch)) : ltc_pkg::is_alpha(ch);
        r.num = ltc_pkg::number_next(t.num, ch);
        for (int k = 0; k < ltc_pkg::NUM_KW; k++) begin
            r.hits[k] = t.hits[k] && (t.text_count < ltc_pkg::kw_len(4'(k)))
                        && (ltc_pkg::kw_char(4'(k), t.text_count[2:0]) == ch);
        end
        if (t.text_count < ltc_pkg::CNT_SAT)
            r.text_count = t.text_count + 1'b1;
        r.has_text = 1'b1;
        return r;
    endfunction

    function automatic ltc_pkg::cls_t classify(input ltc_pkg::text_check_t t);
        logic kw;
        kw = 1'b0;
        for (int k = 0; k < ltc_pkg::NUM_KW; k++) begin
            if (t.hits[k] && (ltc_pkg::kw_len(4'(k)) == t.text_count))
                kw = 1'b1;
        end
        priority if (kw)
            return ltc_pkg::CLS_KEYWORD;
        else if (t.ident_ok)
            return ltc_pkg::CLS_IDENT;
        else if ((t.num == ltc_pkg::NUM_INT) || (t.num == ltc_pkg::NUM_FRAC)
                 || (t.num == ltc_pkg::NUM_EXP_INT))
            return ltc_pkg::CLS_CONST;
        else
            return ltc_pkg::CLS_ERROR;
    endfunction

    function automatic scan_t emit(input scan_t x, input ltc_pkg::cls_t cls,
                                   input logic [7:0] len8);
        scan_t r;
        r = x;
        if (x.grp.count < 2'(ltc_pkg::RES_SLOTS)) begin
            r.grp.items[x.grp.count] = '{token_class: cls, token_length: len8,
                                         last_of_run: 1'b0};
            r.grp.count = x.grp.count + 2'd1;
        end
        return r;
    endfunction

    function automatic scan_t clear_tok(input scan_t x);
        scan_t r;
        r = x;
        r.chk = ltc_pkg::CHK_CLEAR;
        r.len = '0;
        return r;
    endfunction

    function automatic scan_t flush(input scan_t x);
        scan_t r;
        r = x;
        if (x.chk.has_text)
            r = clear_tok(emit(x, classify(x.chk), out_len(x.len)));
        return r;
    endfunction

    function automatic scan_t emit_single(input scan_t x, input ltc_pkg::cls_t cls);
        return clear_tok(emit(x, cls, out_len(sat_inc(x.len))));
    endfunction

    assign c = item.char_code;

    // a held '-' turns into an operator unless a digit follows it
    assign minus_op = minus_reg && ((item.action == ltc_pkg::ACT_EOL)
                      || (!comment_reg && !ltc_pkg::is_digit(c)));

    always_comb
    begin
        s.grp        = '0;
        s.chk        = chk_reg;
        s.len        = len_reg;
        minus_next   = minus_reg;
        comment_next = comment_reg;

        if (minus_op)
        begin
            minus_next = 1'b0;
            s = emit_single(flush(s), ltc_pkg::CLS_OP);
        end

        if (item.action == ltc_pkg::ACT_EOL)
        begin
            if (comment_reg)
                s = emit(s, ltc_pkg::CLS_COMMENT, out_len(s.len));
            else
                s = flush(s);
            s = clear_tok(emit(s, ltc_pkg::CLS_EOL, 8'd0));
            comment_next = 1'b0;
        end
        else if (comment_reg)
        begin
            s.len = sat_inc(s.len);
        end
        else
        begin
            if (minus_reg && ltc_pkg::is_digit(c))
            begin
                minus_next = 1'b0;
                s.chk = feed(s.chk, ltc_pkg::CH_MINUS);
                s.len = sat_inc(s.len);
            end
            unique case (c)
                ltc_pkg::CH_SEMI:
                begin
                    s = clear_tok(flush(s));
                    s.len = LW'(1);
                    comment_next = 1'b1;
                end
                ltc_pkg::CH_SPACE:
                begin
                    s = flush(s);
                    s.len = sat_inc(s.len);
                end
                ltc_pkg::CH_LPAR, ltc_pkg::CH_RPAR, ltc_pkg::CH_LT, ltc_pkg::CH_GT,
                ltc_pkg::CH_EQ, ltc_pkg::CH_COMMA, ltc_pkg::CH_PLUS, ltc_pkg::CH_SLASH:
                begin
                    s = emit_single(flush(s), ltc_pkg::CLS_OP);
                end
                ltc_pkg::CH_MINUS:
                begin
                    minus_next = 1'b1;
                end
                ltc_pkg::CH_STAR:
                begin
                    if (s.len == '0)
                        s = emit_single(s, ltc_pkg::CLS_OP);
                    else if (!s.chk.has_text)
                        s = emit_single(s, ltc_pkg::CLS_ERROR);
                    else
                    begin
                        s.chk = feed(s.chk, c);
                        s.len = sat_inc(s.len);
                    end
                end
                default:
                begin
                    s.chk = feed(s.chk, c);
                    s.len = sat_inc(s.len);
                end
            endcase
        end

        // mark the final result of this transaction
        if (s.grp.count != 2'd0)
            s.grp.items[s.grp.count - 2'd1].last_of_run = 1'b1;
    end

    assign group = s.grp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minus_reg   <= 1'b0;
            comment_reg <= 1'b0;
            chk_reg     <= ltc_pkg::CHK_CLEAR;
            len_reg     <= '0;
        end
        else if (accept)
        begin
            minus_reg   <= minus_next;
            comment_reg <= comment_next;
            chk_reg     <= s.chk;
            len_reg     <= s.len;
        end
    end

    `LTC_ASSERT_HOLD(a_minus_outside_comment, !(minus_reg && comment_reg),
        "held minus inside a comment")
    `LTC_ASSERT_IMP(a_eol_gives_result, accept && (item.action == ltc_pkg::ACT_EOL),
        group.count != 2'd0, "end of line produced no token")

endmodule

/* hw/rtl/ltc_queue.sv */
module ltc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ltc_pkg::token_group_t push_group,
    output logic                  space,
    output logic                  token_valid,
    input  logic                  token_ready,
    output ltc_pkg::token_item_t  token_item
);

    `include "line_token_classifier_assert.svh"

    localparam logic [1:0] QDEPTH = 2'd2;

    ltc_pkg::token_group_t entry_reg [2];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            count_reg, count_next;
    logic [1:0]            idx_reg;
    ltc_pkg::token_group_t head;
    logic                  take, pop;

    assign head        = entry_reg[rd_ptr_reg];
    assign token_valid = (count_reg != 2'd0);
    assign token_item  = head.items[idx_reg];
    assign space       = (count_reg < QDEPTH);
    assign take        = token_valid && token_ready;
    assign pop         = take && (idx_reg == head.count - 2'd1);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
                idx_reg    <= 2'd0;
            end
            else if (take)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    `LTC_ASSERT_HOLD(a_count_bound, count_reg <= QDEPTH, "group queue overflow")
    `LTC_ASSERT_IMP(a_idx_in_group, token_valid,
        (head.count != 2'd0) && (idx_reg < head.count), "read index outside group")
    `LTC_ASSERT_NEXT(a_push_counts, push && !pop,
        count_reg == $past(count_reg) + 2'd1, "push not counted")

endmodule
